// File: hdl/sseg_pkg.sv
// Shared types and constants of the seven-segment text encoder.
`timescale 1ns / 1ps

package sseg_pkg;

	localparam int NUM_DIGITS = 4;
	localparam int NUM_SLOTS  = 4;
	localparam int POS_W      = ($clog2(NUM_DIGITS + 1) < 2) ? 2 : $clog2(NUM_DIGITS + 1);
	localparam int ELAPSED_W  = 17;

	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
	localparam logic [7:0] UNKNOWN_GLYPH = 8'b0001_0000;
	localparam logic [7:0] CHAR_DOT      = 8'h2E;

	localparam logic [7:0]  DIGIT_WIRING_RST     = 8'd228;
	localparam logic [23:0] SEGMENT_WIRING_RST   = 24'd16434824;
	localparam logic [15:0] DISPLAY_DURATION_RST = 16'd1500;

	typedef enum logic [1:0] {
		REG_DIGIT_WIRING     = 2'd0,
		REG_SEGMENT_WIRING   = 2'd1,
		REG_DISPLAY_DURATION = 2'd2
	} reg_index_t;

	typedef enum logic {
		MODE_TEXT = 1'b0,
		MODE_TICK = 1'b1
	} mode_t;

	typedef logic [NUM_SLOTS-1:0][7:0] frame_t;

	typedef struct packed {
		logic [7:0]  digit_wiring;
		logic [23:0] segment_wiring;
		logic [15:0] display_duration;
	} cfg_t;

	typedef struct packed {
		logic [7:0] glyph_mask;
		logic [7:0] point_mask;
	} seg_masks_t;

	typedef struct packed {
		logic   emit;
		frame_t digits;
		logic   blanked;
	} result_t;

endpackage

// File: hdl/seven_segment_text_encoder.sv
// Top level of the seven-segment text encoder: handshakes, registers, result stage.
`timescale 1ns / 1ps

// Seven-segment text encoder. Feed a string one character per request (mode 0);
// the request flagged last_char yields one frame of four physical digit bytes with
// blanked = 0. Tick requests (mode 1) count time after a frame and yield one frame
// of zeros with blanked = 1 once more ticks than display_duration have passed.
// Other requests yield nothing. Throughput is one request per cycle while nothing
// is held back: a request is registered, then the font lookup, segment/digit rewiring
// and the position, frame and timer update run combinationally into the result
// register. The only back-pressure comes from the result register: a request that
// would produce a result waits in the input stage while an earlier result is held
// by out_stall; requests that produce nothing keep flowing. Configuration writes
// are always ready and take effect on the next cycle; write them only while the
// block is idle.
module seven_segment_text_encoder (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [7:0]  character,
	input  logic        last_char,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  digit_zero,
	output logic [7:0]  digit_one,
	output logic [7:0]  digit_two,
	output logic [7:0]  digit_three,
	output logic        blanked,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	import sseg_pkg::*;

	cfg_t    cfg_q;
	logic    valid_s1;
	logic    mode_s1;
	logic [7:0] character_s1;
	logic    last_char_s1;
	result_t res;
	logic    advance;
	logic    out_free;
	logic    out_valid_q;
	frame_t  digits_q;
	logic    blanked_q;

	// Configuration registers: always ready, unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.digit_wiring     <= DIGIT_WIRING_RST;
			cfg_q.segment_wiring   <= SEGMENT_WIRING_RST;
			cfg_q.display_duration <= DISPLAY_DURATION_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DIGIT_WIRING:     cfg_q.digit_wiring     <= cfg_data[7:0];
				REG_SEGMENT_WIRING:   cfg_q.segment_wiring   <= cfg_data;
				REG_DISPLAY_DURATION: cfg_q.display_duration <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Result slot is free when empty or being taken this cycle.
	assign out_free = !out_valid_q || !out_stall;
	// Advance the input stage unless its result would land on a held one.
	assign advance  = valid_s1 && (!res.emit || out_free);
	// Hold new requests while the input stage is blocked.
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_s1      <= mode;
			character_s1 <= character;
			last_char_s1 <= last_char;
		end
	end

	sseg_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.mode      (mode_s1),
		.character (character_s1),
		.last_char (last_char_s1),
		.cfg       (cfg_q),
		.res       (res)
	);

	// Result register: load on a producing advance, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			digits_q  <= res.digits;
			blanked_q <= res.blanked;
		end
	end

	assign out_valid   = out_valid_q;
	assign digit_zero  = digits_q[0];
	assign digit_one   = digits_q[1];
	assign digit_two   = digits_q[2];
	assign digit_three = digits_q[3];
	assign blanked     = blanked_q;

`ifndef NO_ASSERTIONS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !(advance && res.emit))
		else $error("held result overwritten");

	a_stall_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && res.emit && out_valid_q)
		else $error("input stalled without a blocked result");

	a_blank_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && blanked_q |-> digits_q == '0)
		else $error("blanking result carries segments");
`endif

endmodule

// File: hdl/sseg_glyph.sv
// Font lookup and segment rewiring of one character.
`timescale 1ns / 1ps

module sseg_glyph (
	input  logic [7:0]          character,
	input  logic [23:0]         segment_wiring,
	output sseg_pkg::seg_masks_t masks
);
	import sseg_pkg::*;

	logic [7:0] glyph;

	// Font: bit 7..0 = segments A B C D E F G dot
	always_comb begin
		unique case (character)
			8'h20: glyph = 8'h00; // ' '
			8'h2D: glyph = 8'h02; // '-'
			8'h30: glyph = 8'hFC;
			8'h31: glyph = 8'h60;
			8'h32: glyph = 8'hDA;
			8'h33: glyph = 8'hF2;
			8'h34: glyph = 8'h66;
			8'h35: glyph = 8'hB6;
			8'h36: glyph = 8'hBE;
			8'h37: glyph = 8'hE0;
			8'h38: glyph = 8'hFE;
			8'h39: glyph = 8'hF6;
			8'h41: glyph = 8'hEE; // 'A'
			8'h45: glyph = 8'h9E; // 'E'
			8'h48: glyph = 8'h6E; // 'H'
			8'h68: glyph = 8'h2E; // 'h'
			8'h4F: glyph = 8'hFC; // 'O'
			8'h53: glyph = 8'hB6; // 'S'
			8'h65: glyph = 8'h9E; // 'e'
			8'h69: glyph = 8'h08; // 'i'
			8'h6D: glyph = 8'h2A; // 'm'
			8'h6E: glyph = 8'h2A; // 'n'
			8'h6F: glyph = 8'h3A; // 'o'
			8'h50: glyph = 8'hCE; // 'P'
			8'h73: glyph = 8'hB6; // 's'
			8'h74: glyph = 8'h1E; // 't'
			8'h75: glyph = 8'h38; // 'u'
			8'h76: glyph = 8'h38; // 'v'
			default: glyph = UNKNOWN_GLYPH;
		endcase
	end

	// Move each glyph bit to its physical segment bit; collisions OR together.
	always_comb begin
		masks.glyph_mask = '0;
		for (int n = 0; n < 8; n++) begin
			if (glyph[n]) begin
				masks.glyph_mask[segment_wiring[3*n +: 3]] = 1'b1;
			end
		end
		masks.point_mask = '0;
		masks.point_mask[segment_wiring[2:0]] = 1'b1;
	end

endmodule

// File: hdl/sseg_frame.sv
// Frame builder and display timeout timer.
`timescale 1ns / 1ps

module sseg_frame (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic                 mode,
	input  logic [7:0]           character,
	input  logic                 last_char,
	input  sseg_pkg::cfg_t       cfg,
	output sseg_pkg::result_t    res
);
	import sseg_pkg::*;

	logic [POS_W-1:0]     pos_q, pos_n;
	frame_t               frame_q, frame_n, frame_calc;
	logic [ELAPSED_W-1:0] elapsed_q, elapsed_n, elapsed_inc;
	logic                 running_q, running_n;
	seg_masks_t           masks;
	logic [POS_W-1:0]     pos_prev;
	logic [1:0]           slot_cur, slot_prev;
	logic                 is_dot;

	sseg_glyph u_glyph (
		.character      (character),
		.segment_wiring (cfg.segment_wiring),
		.masks          (masks)
	);

	function automatic logic [1:0] slot_of(input logic [7:0] wiring, input logic [1:0] p);
		slot_of = wiring[{p, 1'b0} +: 2];
	endfunction

	assign pos_prev    = pos_q - POS_W'(1);
	assign slot_cur    = slot_of(cfg.digit_wiring, pos_q[1:0]);
	assign slot_prev   = slot_of(cfg.digit_wiring, pos_prev[1:0]);
	assign is_dot      = (character == CHAR_DOT);
	assign elapsed_inc = (elapsed_q != ELAPSED_MAX) ? elapsed_q + ELAPSED_W'(1) : elapsed_q;

	always_comb begin
		frame_calc = frame_q;
		frame_n    = frame_q;
		pos_n      = pos_q;
		elapsed_n  = elapsed_q;
		running_n  = running_q;
		res.emit    = 1'b0;
		res.digits  = '0;
		res.blanked = 1'b0;

		if (mode == MODE_TICK) begin
			if (running_q) begin
				elapsed_n = elapsed_inc;
				if (elapsed_inc > {1'b0, cfg.display_duration}) begin
					res.emit    = 1'b1;
					res.blanked = 1'b1;
					running_n   = 1'b0;
				end
			end
		end else begin
			if (is_dot && pos_q != '0) begin
				frame_calc[slot_prev] = frame_q[slot_prev] | masks.point_mask;
			end else if (pos_q < POS_W'(NUM_DIGITS)) begin
				frame_calc[slot_cur] = frame_q[slot_cur] | masks.glyph_mask;
				pos_n = pos_q + POS_W'(1);
			end
			frame_n = frame_calc;
			if (last_char) begin
				res.emit   = 1'b1;
				res.digits = frame_calc;
				frame_n    = '0;
				pos_n      = '0;
				elapsed_n  = '0;
				running_n  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			frame_q   <= '0;
			elapsed_q <= '0;
			running_q <= 1'b0;
		end else if (advance) begin
			pos_q     <= pos_n;
			frame_q   <= frame_n;
			elapsed_q <= elapsed_n;
			running_q <= running_n;
		end
	end

`ifndef NO_ASSERTIONS
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(NUM_DIGITS))
		else $error("digit position past the last digit");

	a_blank_stops: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.emit && res.blanked |=> !running_q)
		else $error("timer still running after blanking");

	a_render_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.emit && !res.blanked |=>
		pos_q == '0 && frame_q == '0 && elapsed_q == '0 && running_q)
		else $error("string state not restarted after a frame");

	a_idle_tick_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		mode == MODE_TICK && !running_q |-> !res.emit)
		else $error("tick produced a result with the timer stopped");
`endif

endmodule

// File: dv/seven_segment_text_encoder_tb.sv
// Self-checking testbench of the seven-segment text encoder: table-driven and random requests.
`timescale 1ns / 1ps

// The bench sends character and tick requests through the valid/stall channel and
// predicts every frame from its own copy of the font, wiring registers, position,
// frame bytes and timer. A directed table runs first, then eight random phases.
// Each phase is configured while the block is idle. The phases cover shared
// slots, the all-ones wiring, the reset wiring and random wiring, a long
// receiver hold-off, a stretch with no gaps, and a sender pause that drains
// the block.
module seven_segment_text_encoder_tb;
	import sseg_pkg::*;

	localparam int          CLK_HALF      = 6;
	localparam int          CYCLE_LIMIT   = 300000;
	localparam int          HOLD_CYCLES   = 300;
	localparam int          PHASE_COUNT   = 8;
	localparam int          PHASE_ITEMS   = 115;
	localparam int          MAX_REPORTS   = 10;
	localparam int          DRAIN_CYCLES  = 8;
	localparam logic [1:0]  REG_UNUSED    = 2'd3;

	localparam logic [7:0] FONT_CODES [28] = '{
		" ", "-", "0", "1", "2", "3", "4", "5", "6", "7",
		"8", "9", "A", "E", "H", "h", "O", "S", "e", "i",
		"m", "n", "o", "P", "s", "t", "u", "v"
	};
	// bit 7..0 = segments A B C D E F G and the point
	localparam logic [7:0] FONT_GLYPHS [28] = '{
		8'h00, 8'h02, 8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0,
		8'hFE, 8'hF6, 8'hEE, 8'h9E, 8'h6E, 8'h2E, 8'hFC, 8'hB6, 8'h9E, 8'h08,
		8'h2A, 8'h2A, 8'h3A, 8'hCE, 8'hB6, 8'h1E, 8'h38, 8'h38
	};

	typedef struct packed {
		frame_t seg;
		logic   blanked;
	} display_frame_t;

	// One row of the directed table. Where typed is set, seg is the frame that
	// the request must produce; every other row is left to the predictor.
	typedef struct packed {
		mode_t      m;
		logic [7:0] ch;
		logic       last;
		logic       typed;
		frame_t     seg;
	} text_row_t;

	localparam int DIRECTED_COUNT = 25;
	localparam text_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		// tick with the timer stopped: nothing comes back
		'{MODE_TICK, 8'hFF, 1'b1, 1'b0, 32'h0},
		// reset wiring is the identity: plain eights
		'{MODE_TEXT, "8",   1'b0, 1'b0, 32'h0},
		'{MODE_TEXT, "8",   1'b0, 1'b0, 32'h0},
		'{MODE_TEXT, "8",   1'b0, 1'b0, 32'h0},
		'{MODE_TEXT, "8",   1'b1, 1'b1, 32'hFEFEFEFE},
		// a dot after every digit, the last request being a dot
		'{MODE_TEXT, "8",   1'b0, 1'b0, 32'h0},
		'{MODE_TEXT, ".",   1'b0, 1'b0, 32'h0},
		'{MODE_TEXT, "8",   1'b0, 1'b0, 32'h0},
		'{MODE_TEXT, ".",   1'b0, 1'b0, 32'h0},
		'{MODE_TEXT, "8",   1'b0, 1'b0, 32'h0},
		'{MODE_TEXT, ".",   1'b0, 1'b0, 32'h0},
		'{MODE_TEXT, "8",   1'b0, 1'b0, 32'h0},
		'{MODE_TEXT, ".",   1'b1, 1'b1, 32'hFFFFFFFF},
		// leading dot and unknown code both draw the bottom segment
		'{MODE_TEXT, ".",   1'b0, 1'b0, 32'h0},
		'{MODE_TEXT, "Z",   1'b0, 1'b0, 32'h0},
		'{MODE_TEXT, " ",   1'b0, 1'b0, 32'h0},
		'{MODE_TEXT, "-",   1'b1, 1'b1, 32'h02001010},
		// fifth digit dropped, the dot after it still marks the fourth
		'{MODE_TEXT, "0",   1'b0, 1'b0, 32'h0},
		'{MODE_TEXT, "1",   1'b0, 1'b0, 32'h0},
		'{MODE_TEXT, "2",   1'b0, 1'b0, 32'h0},
		'{MODE_TEXT, "3",   1'b0, 1'b0, 32'h0},
		'{MODE_TEXT, "4",   1'b0, 1'b0, 32'h0},
		'{MODE_TEXT, ".",   1'b1, 1'b1, 32'hF3DA60FC},
		// top code alone, then one tick inside the display time
		'{MODE_TEXT, 8'hFF, 1'b1, 1'b1, 32'h00000010},
		'{MODE_TICK, 8'h00, 1'b0, 1'b0, 32'h0}
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        mode;
	logic [7:0]  character;
	logic        last_char;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  digit_zero;
	logic [7:0]  digit_one;
	logic [7:0]  digit_two;
	logic [7:0]  digit_three;
	logic        blanked;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [23:0] cfg_data;

	// Predictor state: registers, digits drawn, frame under construction, timer.
	cfg_t             cfg_shadow;
	logic [POS_W-1:0] text_pos;
	frame_t           building;
	logic [16:0]      ticks_seen;
	logic             timer_live;

	display_frame_t   pending_frames [$];
	int               mismatch_count;
	int               cycle_count;
	bit               calm;
	bit               hold_long;

	seven_segment_text_encoder u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.character  (character),
		.last_char  (last_char),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.digit_zero (digit_zero),
		.digit_one  (digit_one),
		.digit_two  (digit_two),
		.digit_three(digit_three),
		.blanked    (blanked),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #(CLK_HALF) clk = ~clk;

	// Gap length: mostly from the short range, now and then from the long one.
	function automatic int gap_len();
		if ($urandom_range(0, 4) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [7:0] font_glyph(input logic [7:0] code);
		int i;
		for (i = 0; i < 28; i++) begin
			if (FONT_CODES[i] == code)
				return FONT_GLYPHS[i];
		end
		return UNKNOWN_GLYPH;
	endfunction

	// Mostly font characters, some dots, some arbitrary codes.
	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return FONT_CODES[$urandom_range(0, 27)];
		if (r < 85)
			return CHAR_DOT;
		return 8'($urandom_range(0, 255));
	endfunction

	// Advance the predictor by one accepted request; report the frame it yields.
	task automatic encode_request(input logic m, input logic [7:0] c, input logic l,
			output bit emits, output display_frame_t res);
		logic [1:0] slot;
		logic [7:0] glyph;
		int         p;
		int         n;
		emits = 1'b0;
		res = '0;
		if (m == MODE_TICK) begin
			// ticks leave the string alone and only count while a frame is shown
			if (timer_live) begin
				if (ticks_seen != ELAPSED_MAX)
					ticks_seen++;
				if (ticks_seen > {1'b0, cfg_shadow.display_duration}) begin
					emits = 1'b1;
					res.blanked = 1'b1;
					timer_live = 1'b0;
				end
			end
		end else begin
			if (text_pos != 0 && c == CHAR_DOT) begin
				// point of the previous digit, even past the last drawn one
				p = (int'(text_pos) - 1) & 3;
				slot = cfg_shadow.digit_wiring[2*p +: 2];
				building[slot][cfg_shadow.segment_wiring[2:0]] = 1'b1;
			end else if (text_pos < NUM_DIGITS) begin
				// a leading dot lands here and shows as an unknown glyph
				p = int'(text_pos) & 3;
				slot = cfg_shadow.digit_wiring[2*p +: 2];
				glyph = font_glyph(c);
				for (n = 0; n < 8; n++) begin
					if (glyph[n])
						building[slot][cfg_shadow.segment_wiring[3*n +: 3]] = 1'b1;
				end
				text_pos++;
			end
			if (l) begin
				emits = 1'b1;
				res.seg = building;
				res.blanked = 1'b0;
				ticks_seen = '0;
				timer_live = 1'b1;
				text_pos = '0;
				building = '0;
			end
		end
	endtask

	// Offer one request from a falling edge; hold it until accepted, then
	// record the expected frame and maybe leave a gap.
	task automatic send_request(input mode_t m, input logic [7:0] c, input logic l,
			input logic typed, input frame_t typed_seg);
		bit             emits;
		display_frame_t res;
		in_valid = 1'b1;
		mode = m;
		character = c;
		last_char = l;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		encode_request(m, c, l, emits, res);
		if (emits) begin
			if (typed) begin
				res.seg = typed_seg;
				res.blanked = 1'b0;
			end
			pending_frames.push_back(res);
		end
		@(negedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat (gap_len()) @(negedge clk);
		end
	endtask

	// Drain: drop valid, wait for every frame, then cover the pipeline latency
	// for requests that produce nothing.
	task automatic wait_idle();
		in_valid = 1'b0;
		while (pending_frames.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [23:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_DIGIT_WIRING:     cfg_shadow.digit_wiring = data[7:0];
			REG_SEGMENT_WIRING:   cfg_shadow.segment_wiring = data;
			REG_DISPLAY_DURATION: cfg_shadow.display_duration = data[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Per-phase settings: both extremes, the reset values, then random wiring
	// with short display times so that blanking happens often.
	task automatic configure_phase(input int ph);
		case (ph)
			0: begin
				write_register(REG_DIGIT_WIRING, 24'h0);
				write_register(REG_SEGMENT_WIRING, 24'h0);
				write_register(REG_DISPLAY_DURATION, 24'h0);
			end
			1: begin
				write_register(REG_DIGIT_WIRING, 24'hFFFFFF);
				write_register(REG_SEGMENT_WIRING, 24'hFFFFFF);
				write_register(REG_DISPLAY_DURATION, 24'hFFFFFF);
			end
			2: begin
				write_register(REG_DIGIT_WIRING, 24'(DIGIT_WIRING_RST));
				write_register(REG_SEGMENT_WIRING, SEGMENT_WIRING_RST);
				write_register(REG_DISPLAY_DURATION, 24'(DISPLAY_DURATION_RST));
			end
			default: begin
				write_register(REG_DIGIT_WIRING, 24'($urandom()));
				write_register(REG_SEGMENT_WIRING, 24'($urandom()));
				write_register(REG_DISPLAY_DURATION,
					{8'($urandom()), 16'($urandom_range(0, 24))});
				// the spare index must not disturb any register
				if (ph == 3)
					write_register(REG_UNUSED, 24'($urandom()));
			end
		endcase
	endtask

	// Random requests: mostly strings ended by last_char, with tick bursts,
	// stray ticks inside strings and fully random noise.
	task automatic run_random(input int count, input int pause_at);
		int sent;
		int len;
		int k;
		int r;
		sent = 0;
		while (sent < count) begin
			if (sent >= pause_at && pause_at >= 0) begin
				// hold the sender until every frame has come out
				in_valid = 1'b0;
				while (pending_frames.size() != 0)
					@(negedge clk);
				pause_at = -1;
			end
			r = $urandom_range(0, 99);
			if (r < 70) begin
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
				for (k = 0; k < len; k++) begin
					if ($urandom_range(0, 9) == 0) begin
						send_request(MODE_TICK, 8'($urandom()), 1'($urandom()), 1'b0, '0);
						sent++;
					end
					send_request(MODE_TEXT, pick_char(), k == len - 1, 1'b0, '0);
					sent++;
				end
			end else if (r < 88) begin
				len = $urandom_range(1, 30);
				for (k = 0; k < len; k++)
					send_request(MODE_TICK, 8'($urandom()), 1'($urandom()), 1'b0, '0);
				sent += len;
			end else begin
				send_request(mode_t'($urandom_range(0, 1)), 8'($urandom()),
					1'($urandom()), 1'b0, '0);
				sent++;
			end
		end
	endtask

	// Compare each accepted frame with the oldest expectation.
	always @(posedge clk) begin : check_frames
		display_frame_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_frames.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected frame: %h %h %h %h blanked=%b",
						digit_zero, digit_one, digit_two, digit_three, blanked);
			end else begin
				want = pending_frames.pop_front();
				if (digit_zero !== want.seg[0] || digit_one !== want.seg[1] ||
						digit_two !== want.seg[2] || digit_three !== want.seg[3] ||
						blanked !== want.blanked) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("frame mismatch: expected %h %h %h %h blanked=%b, got %h %h %h %h blanked=%b",
							want.seg[0], want.seg[1], want.seg[2], want.seg[3], want.blanked,
							digit_zero, digit_one, digit_two, digit_three, blanked);
				end
			end
		end
	end

	// Receiver: random stalls, one long hold-off on request, none while calm.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_long) begin
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall = 1'b0;
				hold_long = 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_stall = 1'b1;
				repeat (gap_len()) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	// Watchdog: end the run if it takes far longer than the slowest good run.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int i;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_TEXT;
		character = 8'h00;
		last_char = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_DIGIT_WIRING;
		cfg_data = '0;
		calm = 1'b0;
		hold_long = 1'b0;
		mismatch_count = 0;
		cfg_shadow.digit_wiring = DIGIT_WIRING_RST;
		cfg_shadow.segment_wiring = SEGMENT_WIRING_RST;
		cfg_shadow.display_duration = DISPLAY_DURATION_RST;
		text_pos = '0;
		building = '0;
		ticks_seen = '0;
		timer_live = 1'b0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table with the reset configuration
		for (i = 0; i < DIRECTED_COUNT; i++)
			send_request(DIRECTED_ROWS[i].m, DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].last,
				DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].seg);

		for (i = 0; i < PHASE_COUNT; i++) begin
			wait_idle();
			configure_phase(i);
			// switch the receiver mode on a rising edge so it never races
			@(posedge clk);
			hold_long = (i == 4);
			calm = (i == 5);
			@(negedge clk);
			run_random(PHASE_ITEMS, (i == 6) ? 60 : -1);
		end

		in_valid = 1'b0;
		while (pending_frames.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatch_count == 0 && pending_frames.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// File: seven_segment_text_encoder.f
hdl/sseg_pkg.sv
hdl/sseg_glyph.sv
hdl/sseg_frame.sv
hdl/seven_segment_text_encoder.sv
dv/seven_segment_text_encoder_tb.sv
